@@ sv/r2y_pkg.sv @@
package r2y_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 16;

  // Register widths.
  localparam int FW_W     = 12;
  localparam int FH_W     = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  // Counters and line buffer geometry.
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOTS  = MAX_WIDTH / 2;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int DIM_W  = ((WMAX_W > FH_W) ? WMAX_W : FH_W) + 1;

  // Arithmetic widths.
  localparam int COEF_W  = COEF_FRAC_BITS;
  localparam int PROD_W  = COEF_FRAC_BITS + 8;
  localparam int PIX_C_W = COEF_FRAC_BITS + 8;
  localparam int PAIR_W  = COEF_FRAC_BITS + 9;
  localparam int SUM4_W  = COEF_FRAC_BITS + 10;
  localparam int T_W     = COEF_FRAC_BITS + 12;
  localparam int LB_W    = 2 * PAIR_W;

  // Coefficient magnitudes, c * 2^F rounded to nearest.
  localparam logic [COEF_W-1:0] KY_R =
    COEF_W'(((longint'(2126) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KY_G =
    COEF_W'(((longint'(7152) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KY_B =
    COEF_W'(((longint'(722) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KU_R =
    COEF_W'(((longint'(1146) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KU_G =
    COEF_W'(((longint'(3854) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KU_B =
    COEF_W'(((longint'(5000) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KV_R =
    COEF_W'(((longint'(5000) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KV_G =
    COEF_W'(((longint'(4542) << COEF_FRAC_BITS) + 5000) / 10000);
  localparam logic [COEF_W-1:0] KV_B =
    COEF_W'(((longint'(458) << COEF_FRAC_BITS) + 5000) / 10000);

  localparam logic [PROD_W-1:0] Y_HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);

  // 128 offset and half-step rounding of the four-pixel average.
  localparam logic signed [T_W-1:0] CH_OFS =
    T_W'((longint'(128) << (COEF_FRAC_BITS + 2)) + (longint'(1) << (COEF_FRAC_BITS + 1)));

  typedef struct packed {
    logic keep;
    logic col_odd;
    logic row_odd;
    logic frame_end;
  } flags_t;

  typedef struct packed {
    logic       is_chroma;
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       last_of_run;
    logic       frame_end;
  } beat_t;

  function automatic logic [7:0] chroma_out(input logic signed [SUM4_W-1:0] sum4);
    logic signed [T_W-1:0] t;
    logic [T_W-COEF_FRAC_BITS-3:0] q;
    t = T_W'(sum4) + CH_OFS;
    q = t[T_W-1:COEF_FRAC_BITS+2];
    if (t[T_W-1]) begin
      return 8'd0;
    end else if (q > (T_W-COEF_FRAC_BITS-2)'(255)) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage

@@ sv/r2y_ram.sv @@
module r2y_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/r2y_color.sv @@
module r2y_color (
  input  logic [7:0]                           red,
  input  logic [7:0]                           green,
  input  logic [7:0]                           blue,
  output logic [7:0]                           luma,
  output logic signed [r2y_pkg::PIX_C_W-1:0]   cb,
  output logic signed [r2y_pkg::PIX_C_W-1:0]   cr
);
  import r2y_pkg::*;

  logic [PROD_W-1:0] p_yr, p_yg, p_yb;
  logic [PROD_W-1:0] p_ur, p_ug, p_ub;
  logic [PROD_W-1:0] p_vr, p_vg, p_vb;
  logic [PROD_W-1:0] y_sum;
  logic signed [PIX_C_W:0] cb_w, cr_w;

  assign p_yr = KY_R * red;
  assign p_yg = KY_G * green;
  assign p_yb = KY_B * blue;
  assign p_ur = KU_R * red;
  assign p_ug = KU_G * green;
  assign p_ub = KU_B * blue;
  assign p_vr = KV_R * red;
  assign p_vg = KV_G * green;
  assign p_vb = KV_B * blue;

  // The luma coefficients add up to about one, so the rounded sum never
  // reaches 256 and the integer part fits in eight bits.
  assign y_sum = p_yr + p_yg + p_yb + Y_HALF;
  assign luma  = y_sum[PROD_W-1:COEF_FRAC_BITS];

  assign cb_w = $signed({1'b0, p_ub}) - $signed({1'b0, p_ur}) - $signed({1'b0, p_ug});
  assign cr_w = $signed({1'b0, p_vr}) - $signed({1'b0, p_vg}) - $signed({1'b0, p_vb});
  assign cb   = cb_w[PIX_C_W-1:0];
  assign cr   = cr_w[PIX_C_W-1:0];

endmodule

@@ sv/rgb_to_yuv420_converter.sv @@
// Pipeline: a luma beat passes through the stage 1, stage 2 and output registers; a chroma beat
// follows in the next cycle after the luma beat is taken.
// Throughput: one pixel per cycle while the result side accepts; a pixel on an odd row and odd
// column yields two beats on the single result channel, so odd rows hold the input back.
// Reset: counters cleared, frame size 640 x 480; the line buffer RAM is not cleared.
module rgb_to_yuv420_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [r2y_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_chroma,
  output logic [7:0]                       out_luma,
  output logic [7:0]                       out_chroma_blue,
  output logic [7:0]                       out_chroma_red,
  output logic                             out_last_of_run,
  output logic                             out_frame_end
);
  import r2y_pkg::*;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;
  logic [DIM_W-1:0] fw_eff, fh_eff, cw, ch, col_ext, row_ext;

  logic   in_acc;
  flags_t in_flags;

  logic             s1_valid_r;
  flags_t           s1_flags_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [7:0]       s1_red_r, s1_green_r, s1_blue_r;

  logic                       s2_valid_r;
  flags_t                     s2_flags_r;
  logic [SLOT_W-1:0]          s2_slot_r;
  logic [7:0]                 s2_luma_r;
  logic signed [PIX_C_W-1:0]  s2_cb_r, s2_cr_r;
  logic [LB_W-1:0]            s2_upper_r;

  logic [7:0]                 c_luma;
  logic signed [PIX_C_W-1:0]  c_cb, c_cr;

  logic signed [PIX_C_W-1:0]  left_cb_r, left_cr_r;
  logic signed [PAIR_W-1:0]   pair_cb, pair_cr, up_cb, up_cr;
  logic signed [SUM4_W-1:0]   sum4_cb, sum4_cr;

  logic [LB_W-1:0] lb_rdata;
  logic            lb_we;

  logic  s1_go, s2_go, out_free;
  logic  out_valid_r, out_valid_nxt, pend_valid_r, pend_valid_nxt;
  beat_t out_beat_r, out_beat_nxt, pend_beat_r, pend_beat_nxt;
  beat_t luma_beat, chroma_beat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective and cropped frame size.
  always_comb begin
    fw_eff = DIM_W'(frame_width_r);
    if (fw_eff == '0) begin
      fw_eff = DIM_W'(1);
    end else if (fw_eff > DIM_W'(MAX_WIDTH)) begin
      fw_eff = DIM_W'(MAX_WIDTH);
    end
    fh_eff = DIM_W'(frame_height_r);
    if (fh_eff == '0) begin
      fh_eff = DIM_W'(1);
    end else if (fh_eff > DIM_W'(MAX_HEIGHT)) begin
      fh_eff = DIM_W'(MAX_HEIGHT);
    end
    cw = {fw_eff[DIM_W-1:2], 2'b00};
    ch = {fh_eff[DIM_W-1:2], 2'b00};
  end

  // Position of the pixel at the input and the counter advance.
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? '0 : row_r;
    col_ext = DIM_W'(col_cur);
    row_ext = DIM_W'(row_cur);

    in_flags.keep      = (col_ext < cw) && (row_ext < ch);
    in_flags.col_odd   = col_cur[0];
    in_flags.row_odd   = row_cur[0];
    in_flags.frame_end = (col_ext == cw - DIM_W'(1)) && (row_ext == ch - DIM_W'(1));

    if (col_ext + DIM_W'(1) >= fw_eff) begin
      col_nxt = '0;
      row_nxt = (row_ext + DIM_W'(1) >= fh_eff) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  assign s2_go    = s2_valid_r && (!s2_flags_r.keep || out_free);
  assign s1_go    = s1_valid_r && (!s2_valid_r || s2_go);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1: registered pixel; the line buffer read is issued on acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flags_r <= in_flags;
      s1_slot_r  <= col_cur[COL_W-1:1];
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
    end
  end

  r2y_color u_color (
    .red   (s1_red_r),
    .green (s1_green_r),
    .blue  (s1_blue_r),
    .luma  (c_luma),
    .cb    (c_cb),
    .cr    (c_cr)
  );

  // Stage 2: per-pixel values plus the upper pair sums read from the line buffer.
  // The read data stays put while stage 1 stalls, since a read only goes with a new beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!s2_valid_r || s2_go) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_flags_r <= s1_flags_r;
      s2_slot_r  <= s1_slot_r;
      s2_luma_r  <= c_luma;
      s2_cb_r    <= c_cb;
      s2_cr_r    <= c_cr;
      s2_upper_r <= lb_rdata;
    end
  end

  // A slot is written on an even row and read back a full row later, at least four
  // pixels on, so a write always lands before the read of the same slot.
  assign up_cb   = $signed(s2_upper_r[LB_W-1:PAIR_W]);
  assign up_cr   = $signed(s2_upper_r[PAIR_W-1:0]);
  assign pair_cb = PAIR_W'(left_cb_r) + PAIR_W'(s2_cb_r);
  assign pair_cr = PAIR_W'(left_cr_r) + PAIR_W'(s2_cr_r);
  assign sum4_cb = SUM4_W'(up_cb) + SUM4_W'(pair_cb);
  assign sum4_cr = SUM4_W'(up_cr) + SUM4_W'(pair_cr);

  assign lb_we = s2_go && s2_flags_r.keep && s2_flags_r.col_odd && !s2_flags_r.row_odd;

  r2y_ram #(
    .WIDTH (LB_W),
    .DEPTH (SLOTS)
  ) u_line_buf (
    .clk   (clk),
    .we    (lb_we),
    .waddr (s2_slot_r),
    .wdata ({pair_cb, pair_cr}),
    .re    (in_acc),
    .raddr (col_cur[COL_W-1:1]),
    .rdata (lb_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_cb_r <= '0;
      left_cr_r <= '0;
    end else if (s2_go && s2_flags_r.keep && !s2_flags_r.col_odd) begin
      left_cb_r <= s2_cb_r;
      left_cr_r <= s2_cr_r;
    end
  end

  // Output register with one pending chroma beat behind it.
  assign out_free = !out_valid_r || (out_ready && !pend_valid_r);

  always_comb begin
    luma_beat             = '0;
    luma_beat.luma        = s2_luma_r;
    luma_beat.last_of_run = !(s2_flags_r.col_odd && s2_flags_r.row_odd);

    chroma_beat             = '0;
    chroma_beat.is_chroma   = 1'b1;
    chroma_beat.chroma_blue = chroma_out(sum4_cb);
    chroma_beat.chroma_red  = chroma_out(sum4_cr);
    chroma_beat.last_of_run = 1'b1;
    chroma_beat.frame_end   = s2_flags_r.frame_end;

    out_valid_nxt  = out_valid_r;
    out_beat_nxt   = out_beat_r;
    pend_valid_nxt = pend_valid_r;
    pend_beat_nxt  = pend_beat_r;

    if (out_valid_r && out_ready) begin
      if (pend_valid_r) begin
        out_beat_nxt   = pend_beat_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    if (s2_go && s2_flags_r.keep) begin
      out_valid_nxt  = 1'b1;
      out_beat_nxt   = luma_beat;
      pend_valid_nxt = s2_flags_r.col_odd && s2_flags_r.row_odd;
      pend_beat_nxt  = chroma_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r  <= out_beat_nxt;
    pend_beat_r <= pend_beat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_is_chroma   = out_beat_r.is_chroma;
  assign out_luma        = out_beat_r.luma;
  assign out_chroma_blue = out_beat_r.chroma_blue;
  assign out_chroma_red  = out_beat_r.chroma_red;
  assign out_last_of_run = out_beat_r.last_of_run;
  assign out_frame_end   = out_beat_r.frame_end;

endmodule

@@ dv/tb_rgb_to_yuv420_converter.sv @@
module tb_rgb_to_yuv420_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = r2y_pkg::COEF_FRAC_BITS;
  localparam int SLOTS = r2y_pkg::SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEM_TARGET = 700;

  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_e;

  class yuv420_scoreboard;
    r2y_pkg::beat_t yuv_due[$];
    logic [r2y_pkg::FW_W-1:0] width_reg;
    logic [r2y_pkg::FH_W-1:0] height_reg;
    int col, row;
    longint left_cb, left_cr;
    longint upper_cb[SLOTS];
    longint upper_cr[SLOTS];
    longint ky_r, ky_g, ky_b, ku_r, ku_g, ku_b, kv_r, kv_g, kv_b;
    int mismatches, luma_beats, chroma_beats, frame_ends;

    function new();
      ky_r = fixed_coef(2126);
      ky_g = fixed_coef(7152);
      ky_b = fixed_coef(722);
      ku_r = fixed_coef(1146);
      ku_g = fixed_coef(3854);
      ku_b = fixed_coef(5000);
      kv_r = fixed_coef(5000);
      kv_g = fixed_coef(4542);
      kv_b = fixed_coef(458);
      width_reg = r2y_pkg::FW_RESET;
      height_reg = r2y_pkg::FH_RESET;
      col = 0;
      row = 0;
      left_cb = 0;
      left_cr = 0;
      mismatches = 0;
      luma_beats = 0;
      chroma_beats = 0;
      frame_ends = 0;
    endfunction

    // Coefficient given in units of 1e-4, scaled to FRAC fraction bits, rounded.
    static function longint fixed_coef(int ten_thousandths);
      return ((longint'(ten_thousandths) << FRAC) + 5000) / 10000;
    endfunction

    function void write_reg(logic [r2y_pkg::CFG_IDX_W-1:0] idx, logic [r2y_pkg::CFG_W-1:0] data);
      if (idx == r2y_pkg::CFG_FRAME_WIDTH) begin
        width_reg = data[r2y_pkg::FW_W-1:0];
      end else begin
        height_reg = data[r2y_pkg::FH_W-1:0];
      end
    endfunction

    function int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > r2y_pkg::MAX_WIDTH) return r2y_pkg::MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > r2y_pkg::MAX_HEIGHT) return r2y_pkg::MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    // Four-pixel sum to averaged chroma, rounded half up, offset by 128 and clamped.
    function logic [7:0] round_chroma(longint sum4);
      longint t;
      t = sum4 + (longint'(128) << (FRAC + 2)) + (longint'(1) << (FRAC + 1));
      if (t < 0) return 8'd0;
      t = t >>> (FRAC + 2);
      return (t > 255) ? 8'd255 : 8'(t);
    endfunction

    function int pending();
      return yuv_due.size();
    endfunction

    function void queue_beat(r2y_pkg::beat_t beat);
      yuv_due = {yuv_due, beat};
    endfunction

    // Advances the pixel position and queues the beats this pixel must produce.
    function int take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
      int fw, fh, cw, ch, slot, produced;
      longint rv, gv, bv, y, cb, cr;
      r2y_pkg::beat_t luma_beat, chroma_beat;
      fw = active_width();
      fh = active_height();
      cw = fw & ~3;
      ch = fh & ~3;
      produced = 0;
      rv = r;
      gv = g;
      bv = b;
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (col < cw && row < ch) begin
        y = ky_r * rv + ky_g * gv + ky_b * bv + (longint'(1) << (FRAC - 1));
        y = y >>> FRAC;
        cb = ku_b * bv - ku_r * rv - ku_g * gv;
        cr = kv_r * rv - kv_g * gv - kv_b * bv;
        slot = (col >> 1) % SLOTS;
        luma_beat = '{is_chroma: 1'b0, luma: (y > 255) ? 8'd255 : 8'(y), chroma_blue: 8'd0,
                      chroma_red: 8'd0, last_of_run: 1'b1, frame_end: 1'b0};
        produced = 1;
        if (col % 2 == 0) begin
          left_cb = cb;
          left_cr = cr;
        end else if (row % 2 == 0) begin
          upper_cb[slot] = left_cb + cb;
          upper_cr[slot] = left_cr + cr;
        end else begin
          luma_beat.last_of_run = 1'b0;
          chroma_beat = '{is_chroma: 1'b1, luma: 8'd0,
                          chroma_blue: round_chroma(upper_cb[slot] + left_cb + cb),
                          chroma_red: round_chroma(upper_cr[slot] + left_cr + cr),
                          last_of_run: 1'b1,
                          frame_end: (col == cw - 1 && row == ch - 1)};
          produced = 2;
        end
        queue_beat(luma_beat);
        if (produced == 2) queue_beat(chroma_beat);
      end
      if (col + 1 >= fw) begin
        col = 0;
        row = (row + 1 >= fh) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
      return produced;
    endfunction

    function void check_beat(r2y_pkg::beat_t got);
      r2y_pkg::beat_t want;
      if (yuv_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] unexpected beat: chroma=%0b luma=%0d cb=%0d cr=%0d last=%0b end=%0b",
                   $realtime, got.is_chroma, got.luma, got.chroma_blue, got.chroma_red,
                   got.last_of_run, got.frame_end);
        end
        return;
      end
      want = yuv_due.pop_front();
      if (want.is_chroma) chroma_beats++;
      else luma_beats++;
      if (want.frame_end) frame_ends++;
      if (got.is_chroma !== want.is_chroma || got.luma !== want.luma ||
          got.chroma_blue !== want.chroma_blue || got.chroma_red !== want.chroma_red ||
          got.last_of_run !== want.last_of_run || got.frame_end !== want.frame_end) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] beat mismatch: expected chroma=%0b luma=%0d cb=%0d cr=%0d last=%0b end=%0b",
                   $realtime, want.is_chroma, want.luma, want.chroma_blue, want.chroma_red,
                   want.last_of_run, want.frame_end);
          $display("[%0t]                  actual chroma=%0b luma=%0d cb=%0d cr=%0d last=%0b end=%0b",
                   $realtime, got.is_chroma, got.luma, got.chroma_blue, got.chroma_red,
                   got.last_of_run, got.frame_end);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [r2y_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [r2y_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_red, in_green, in_blue;
  logic in_frame_start;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_chroma;
  logic [7:0] out_luma, out_chroma_blue, out_chroma_red;
  logic out_last_of_run, out_frame_end;

  yuv420_scoreboard sb;
  int cycle_count = 0;
  int burst_left = 0;
  int pixels_sent = 0;
  int settings_used = 0;
  int holds_asked = 0;
  int holds_served = 0;
  rx_mode_e rx_mode = RX_STEADY;
  int rx_left = 0;
  int hold_left = 0;

  rgb_to_yuv420_converter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_chroma   (out_is_chroma),
    .out_luma        (out_luma),
    .out_chroma_blue (out_chroma_blue),
    .out_chroma_red  (out_chroma_red),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL rgb_to_yuv420_converter");
    $finish;
  end

  // Result side: a long hold-off when one is asked for, otherwise segments of
  // steady, random or sparse acceptance.
  always @(posedge clk) begin
    if (holds_asked != holds_served) begin
      holds_served = holds_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        case ($urandom_range(0, 2))
          0: rx_mode = RX_STEADY;
          1: rx_mode = RX_RANDOM;
          default: rx_mode = RX_SPARSE;
        endcase
        rx_left = $urandom_range(8, 150);
      end
      rx_left--;
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
        default:   out_ready <= (rx_left % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_beat({out_is_chroma, out_luma, out_chroma_blue, out_chroma_red,
                     out_last_of_run, out_frame_end});
    end
  end

  task automatic program_frame(input bit set_w, input logic [r2y_pkg::CFG_W-1:0] w,
                               input bit set_h, input logic [r2y_pkg::CFG_W-1:0] h);
    if (set_w) begin
      cfg_we <= 1'b1;
      cfg_index <= r2y_pkg::CFG_FRAME_WIDTH;
      cfg_data <= w;
      @(posedge clk);
      sb.write_reg(r2y_pkg::CFG_FRAME_WIDTH, w);
    end
    if (set_h) begin
      cfg_we <= 1'b1;
      cfg_index <= r2y_pkg::CFG_FRAME_HEIGHT;
      cfg_data <= h;
      @(posedge clk);
      sb.write_reg(r2y_pkg::CFG_FRAME_HEIGHT, h);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Offers one pixel, first sitting out a random gap when the current burst is used up.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic fs, output int beats);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = (gap == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats = sb.take_pixel(r, g, b, fs);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Pixels outside the crop give no beat but may still be in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input bit open_frame, input bit restarts,
                           output int kept);
    int beats;
    logic [7:0] px[3];
    logic fs;
    kept = 0;
    for (int i = 0; i < count; i++) begin
      foreach (px[c]) begin
        if ($urandom_range(0, 7) == 0) px[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else px[c] = 8'($urandom());
      end
      fs = (i == 0 && open_frame) || (restarts && $urandom_range(0, 63) == 0);
      send_pixel(px[0], px[1], px[2], fs, beats);
      if (beats > 0) kept++;
    end
    wait_idle();
  endtask

  initial begin
    int kept, beats, random_kept, area, count, prow, pcol;
    logic [23:0] rgb;
    logic [r2y_pkg::CFG_W-1:0] w, h;
    bit set_w, set_h, open_frame;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= r2y_pkg::CFG_FRAME_WIDTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_red <= 8'd0;
    in_green <= 8'd0;
    in_blue <= 8'd0;
    in_frame_start <= 1'b0;
    sb = new();
    random_kept = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A 5x5 frame cropped to 4x4: one 2x2 block each of white, blue, red and a
    // mix of saturated colors and black, with the last row and column dropped.
    program_frame(1'b1, 13'd5, 1'b1, 13'd5);
    for (int i = 0; i < 25; i++) begin
      prow = i / 5;
      pcol = i % 5;
      if (prow == 4 || pcol == 4) begin
        rgb = 24'h808080;
      end else begin
        case ({prow[1], pcol[1]})
          2'b00: rgb = 24'hFFFFFF;
          2'b01: rgb = 24'h0000FF;
          2'b10: rgb = 24'hFF0000;
          default: begin
            case ({prow[0], pcol[0]})
              2'b00: rgb = 24'hFFFF00;
              2'b01: rgb = 24'h00FFFF;
              2'b10: rgb = 24'h000000;
              default: rgb = 24'hFF00FF;
            endcase
          end
        endcase
      end
      send_pixel(rgb[23:16], rgb[15:8], rgb[7:0], i == 0, beats);
    end
    wait_idle();

    // Register extremes, including out-of-range values that saturate. The receiver
    // holds off during the long full-width row so the block backs up and stalls its input.
    program_frame(1'b1, 13'd0, 1'b1, 13'd0);
    run_phase(12, 1'b1, 1'b0, kept);
    program_frame(1'b1, 13'h1FFF, 1'b1, 13'h1FFF);
    holds_asked++;
    run_phase(150, 1'b1, 1'b0, kept);
    program_frame(1'b1, 13'd2048, 1'b1, 13'd4096);
    run_phase(50, 1'b0, 1'b0, kept);
    program_frame(1'b1, 13'd1, 1'b1, 13'd1);
    run_phase(6, 1'b1, 1'b0, kept);
    program_frame(1'b1, 13'd3, 1'b1, 13'd9);
    run_phase(30, 1'b1, 1'b0, kept);
    // Shrinking the frame past the current position wraps both counters.
    program_frame(1'b1, 13'd7, 1'b1, 13'd4096);
    run_phase(60, 1'b1, 1'b0, kept);
    program_frame(1'b1, 13'd4, 1'b1, 13'd4);
    run_phase(40, 1'b0, 1'b0, kept);

    while (pixels_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: begin
          set_w = 1'b0;
          set_h = 1'b0;
        end
        1: begin
          set_w = 1'b1;
          set_h = 1'b0;
        end
        2: begin
          set_w = 1'b0;
          set_h = 1'b1;
        end
        default: begin
          set_w = 1'b1;
          set_h = 1'b1;
        end
      endcase
      if ($urandom_range(0, 11) == 0) begin
        w = 13'($urandom_range(25, 2048));
        h = 13'($urandom_range(13, 300));
      end else begin
        w = 13'($urandom_range(1, 24));
        h = 13'($urandom_range(1, 12));
      end
      // The top bit of the data word is beyond the width register and must be dropped.
      if (w < 13'd4096) w[12] = 1'($urandom_range(0, 1));
      program_frame(set_w, w, set_h, h);
      // A new width starts a fresh frame, so no odd row reads a line buffer entry
      // that its even row never wrote.
      open_frame = set_w || ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) holds_asked++;
      area = sb.active_width() * sb.active_height();
      if (area <= 320) count = area + $urandom_range(0, sb.active_width());
      else count = $urandom_range(1, 200);
      if (count > ITEM_TARGET - pixels_sent) count = ITEM_TARGET - pixels_sent;
      run_phase(count, open_frame, 1'b1, kept);
      random_kept += kept;
    end

    $display("Run drove %0d pixels over %0d frame settings, %0d kept in random phases.",
             pixels_sent, settings_used, random_kept);
    $display("Checked %0d luma and %0d chroma beats (%0d frame ends); %0d mismatches.",
             sb.luma_beats, sb.chroma_beats, sb.frame_ends, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS rgb_to_yuv420_converter");
    end else begin
      $display("FAIL rgb_to_yuv420_converter");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/r2y_pkg.sv
sv/r2y_ram.sv
sv/r2y_color.sv
sv/rgb_to_yuv420_converter.sv
dv/tb_rgb_to_yuv420_converter.sv
